>>> design/efla_pkg.sv
// Shared types, constants and helpers for the explicit free list allocator.
// Used by efla_datapath, efla_ctrl and explicit_free_list_allocator.
package efla_pkg;

  localparam int HEAP_WORDS = 262144;
  localparam int IDX_W      = $clog2(HEAP_WORDS);
  localparam int MAX_WALK   = HEAP_WORDS / 4 + 1;
  localparam int WALK_W     = $clog2(MAX_WALK + 1);
  localparam int ADDR_W     = 20;
  localparam int CHUNK_W    = 17;
  localparam int LIMIT_W    = 21;
  localparam int BRK_W      = 21;
  localparam int WORD_W     = 32;
  localparam logic [WORD_W-1:0] HEAP_CAP  = WORD_W'(HEAP_WORDS) * 32'd4;
  localparam logic [WORD_W-1:0] MIN_BLOCK = 32'd16;
  localparam logic [WORD_W-1:0] TAG_MASK  = ~32'd7;

  // Default register values
  localparam logic [CHUNK_W-1:0] CHUNK_RST = 17'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 21'd1048576;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OOM  = 2'd2
  } status_t;

  // Datapath micro-operations
  typedef enum logic [5:0] {
    U_NOP, U_LATCH, U_SET_ZERO, U_SET_OOM, U_OUT,
    U_INIT_CLR, U_INIT_W0, U_INIT_W1, U_INIT_W2, U_INIT_W3,
    U_GROW_SET, U_GROW_EPI,
    U_TAG_HDR, U_TAG_FTR,
    U_PUSH_A, U_PUSH_B, U_PUSH_C,
    U_RM_A, U_RM_B, U_RM_C, U_RM_D,
    U_MG_A, U_MG_B, U_MG_C,
    U_RD_NBH, U_RD_PBH, U_SZ_ADD, U_SZ_ADD_RD_NBH,
    U_TAGS_BP, U_TAGS_PB, U_BP_PB,
    U_MA_INIT, U_FF_RD, U_FF_NEXT_RD, U_FF_STEP, U_NOFIT,
    U_PL_RD, U_PL_CS, U_PL_SPLIT, U_PL_WHOLE, U_PL_REM, U_PL_RES,
    U_F_RD, U_F_SZ, U_F_TAGS
  } uop_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_ZERO, S_OOM, S_DONE,
    S_I0, S_I1, S_I2, S_I3, S_I4,
    S_G0, S_G1,
    S_T0, S_T1,
    S_P0, S_P1, S_P2,
    S_R0, S_R1, S_R2, S_R3,
    S_MG0, S_MG1, S_MG2, S_MG_END,
    S_MGA0, S_MGA1, S_MGA2, S_MGA3,
    S_MGB0, S_MGB1, S_MGB2, S_MG_BP,
    S_MGC0, S_MGC1, S_MGC2, S_MGC3,
    S_MA0, S_FF0, S_FF1, S_FF2, S_NOFIT,
    S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_PL_END,
    S_F0, S_F1, S_F2
  } ctl_state_t;

  typedef struct packed {
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opc;
    logic    req_zero;
    logic    brk_lt16;
    logic    lim_lt16;
    logic    grow_fail;
    logic    bp_zero;
    logic    walk_max;
    logic    fit;
    logic    pw0;
    logic    rd0;
    logic    split;
    logic    free_pre_ok;
    logic    free_sz_ok;
    logic    out_free;
  } dp_stat_t;

  // Round down to words, then up to an even word count
  function automatic logic [WORD_W-1:0] round_grow(input logic [WORD_W-1:0] bytes);
    logic [WORD_W-1:0] words;
    words = bytes >> 2;
    return ((words + 32'd1) & ~32'd1) << 2;
  endfunction

endpackage

>>> design/explicit_free_list_allocator.sv
// Result timing depends on the item: init ends sooner when out of memory, a
// rejected free sooner than one that coalesces; allocate takes longer for each
// free-list node passed (header and link read on the one heap port) and when the
// heap grows; opcode 3 returns an OK result without acting.
// One item at a time; a result waits in the output register while the next
// item is taken. Reset (rst, synchronous) empties the list, zeroes the break
// and restores the registers; heap words are not cleared.
module explicit_free_list_allocator
  import efla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // opcode[1:0], request_size[21:2], block_address[41:22]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // result_address[19:0], status[21:20]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  assign pready = 1'b1;

  efla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  efla_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

endmodule

>>> design/efla_datapath.sv
// Datapath of the allocator: heap memory, pointer registers, config regs,
// output register. Executes one micro-operation per cycle. Uses efla_pkg.
module efla_datapath
  import efla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            st,
  input  logic [47:0]         s_tdata,   // opcode[1:0], request_size[21:2], block_address[41:22]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // result_address[19:0], status[21:20]
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata
);

  // Config registers
  logic [CHUNK_W-1:0] chunk;
  logic [LIMIT_W-1:0] limit;

  // Latched request
  opcode_t           opc;
  logic [ADDR_W-1:0] req;
  logic [ADDR_W-1:0] addr;

  // Allocator state and scratch registers
  logic [ADDR_W-1:0] hd;
  logic [BRK_W-1:0]  brk;
  logic [WORD_W-1:0] g, bp, sz, nb, pb, pw, prv, nxt, tp, ts, ua, ra, k, cs;
  logic              ta;
  logic [WALK_W-1:0] walk;
  logic [ADDR_W-1:0] res;
  status_t           status;

  // Output register
  logic              out_valid;
  logic [ADDR_W-1:0] out_res;
  status_t           out_st;

  // Heap memory port
  logic [WORD_W-1:0] mem [HEAP_WORDS];
  logic [WORD_W-1:0] mem_addr, mem_wd, mem_q, rdata;
  logic              mem_we, mem_ok, oor_q;
  logic [IDX_W-1:0]  mem_idx;

  logic [WORD_W-1:0] chunk_eff, lim_now, rd_sz;

  assign chunk_eff = (chunk < CHUNK_W'(16)) ? MIN_BLOCK : WORD_W'(chunk);
  assign lim_now   = (WORD_W'(limit) < HEAP_CAP) ? WORD_W'(limit) : HEAP_CAP;
  assign rdata     = oor_q ? '0 : mem_q;
  assign rd_sz     = rdata & TAG_MASK;

  // Status toward the controller
  always_comb begin
    st.opc         = opc;
    st.req_zero    = (req == '0);
    st.brk_lt16    = (WORD_W'(brk) < MIN_BLOCK);
    st.lim_lt16    = (lim_now < MIN_BLOCK);
    st.grow_fail   = ((WORD_W'(brk) + g) > lim_now);
    st.bp_zero     = (bp == '0);
    st.walk_max    = (walk == WALK_W'(MAX_WALK));
    st.fit         = (rd_sz >= k);
    st.pw0         = pw[0];
    st.rd0         = rdata[0];
    st.split       = (cs >= k + MIN_BLOCK);
    st.free_pre_ok = (WORD_W'(brk) >= MIN_BLOCK) && (addr[2:0] == 3'd0) &&
                     (WORD_W'(addr) >= MIN_BLOCK) &&
                     (WORD_W'(addr) < WORD_W'(brk));
    st.free_sz_ok  = (sz >= MIN_BLOCK) &&
                     ((33'(addr) + 33'(sz)) <= 33'(brk));
    st.out_free    = !out_valid || m_tready;
  end

  // Memory address, write enable and write data per micro-op
  always_comb begin
    mem_addr = '0;
    mem_we   = 1'b0;
    mem_wd   = '0;
    unique case (cmd.uop)
      U_INIT_W0: begin mem_addr = 32'd0;  mem_we = 1'b1; mem_wd = 32'd0; end
      U_INIT_W1: begin mem_addr = 32'd4;  mem_we = 1'b1; mem_wd = 32'd9; end
      U_INIT_W2: begin mem_addr = 32'd8;  mem_we = 1'b1; mem_wd = 32'd9; end
      U_INIT_W3: begin mem_addr = 32'd12; mem_we = 1'b1; mem_wd = 32'd1; end
      U_GROW_EPI: begin
        mem_addr = bp + sz - 32'd4; mem_we = 1'b1; mem_wd = 32'd1;
      end
      U_TAG_HDR: begin
        mem_addr = tp - 32'd4; mem_we = 1'b1; mem_wd = ts | WORD_W'(ta);
      end
      U_TAG_FTR: begin
        mem_addr = tp + ts - 32'd8; mem_we = 1'b1; mem_wd = ts | WORD_W'(ta);
      end
      U_PUSH_A: begin
        mem_addr = WORD_W'(hd) + 32'd4; mem_we = (hd != '0); mem_wd = ua;
      end
      U_PUSH_B: begin mem_addr = ua; mem_we = 1'b1; mem_wd = WORD_W'(hd); end
      U_PUSH_C: begin mem_addr = ua + 32'd4; mem_we = 1'b1; mem_wd = '0; end
      U_RM_A:   mem_addr = ra + 32'd4;
      U_RM_B:   mem_addr = ra;
      U_RM_C: begin mem_addr = prv; mem_we = (prv != '0); mem_wd = rdata; end
      U_RM_D: begin
        mem_addr = nxt + 32'd4; mem_we = (nxt != '0); mem_wd = prv;
      end
      U_MG_A:          mem_addr = bp - 32'd8;
      U_MG_B:          mem_addr = nb - 32'd4;
      U_RD_NBH:        mem_addr = nb - 32'd4;
      U_RD_PBH:        mem_addr = pb - 32'd4;
      U_SZ_ADD_RD_NBH: mem_addr = nb - 32'd4;
      U_FF_RD:         mem_addr = bp - 32'd4;
      U_FF_NEXT_RD:    mem_addr = bp;
      U_PL_RD:         mem_addr = bp - 32'd4;
      U_F_RD:          mem_addr = WORD_W'(addr) - 32'd4;
      default: ;
    endcase
  end

  assign mem_ok  = (mem_addr < HEAP_CAP);
  assign mem_idx = mem_addr[IDX_W+1:2];

  // Heap word store, read-first with registered read data
  always_ff @(posedge clk) begin
    if (mem_we && mem_ok) begin
      mem[mem_idx] <= mem_wd;
    end
    mem_q <= mem[mem_idx];
    oor_q <= !mem_ok;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= CHUNK_RST;
      limit <= LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        limit <= pwdata[LIMIT_W-1:0];
      end else begin
        chunk <= pwdata[CHUNK_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? WORD_W'(limit) : WORD_W'(chunk);

  // Control state: list head and break
  always_ff @(posedge clk) begin
    if (rst) begin
      hd  <= '0;
      brk <= '0;
    end else begin
      unique case (cmd.uop)
        U_INIT_CLR: begin hd <= '0; brk <= '0; end
        U_INIT_W3:  brk <= BRK_W'(16);
        U_GROW_SET: brk <= BRK_W'(WORD_W'(brk) + g);
        U_PUSH_C:   hd <= ua[ADDR_W-1:0];
        U_RM_C: begin
          if (prv == '0) begin
            hd <= rdata[ADDR_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Scratch registers
  always_ff @(posedge clk) begin
    unique case (cmd.uop)
      U_LATCH: begin
        opc    <= opcode_t'(s_tdata[1:0]);
        req    <= s_tdata[21:2];
        addr   <= s_tdata[41:22];
        res    <= '0;
        status <= ST_OK;
      end
      U_SET_ZERO: status <= ST_ZERO;
      U_SET_OOM:  status <= ST_OOM;
      U_INIT_W3:  g <= round_grow(chunk_eff);
      U_GROW_SET: begin
        bp <= WORD_W'(brk); sz <= g; tp <= WORD_W'(brk); ts <= g; ta <= 1'b0;
      end
      U_RM_B:   prv <= rdata;
      U_RM_C:   nxt <= rdata;
      U_MG_A:   nb <= bp + sz;
      U_MG_B:   pw <= rdata;
      U_MG_C: begin
        pb <= bp - (pw & TAG_MASK); ra <= nb; ua <= bp;
      end
      U_SZ_ADD:        sz <= sz + rd_sz;
      U_SZ_ADD_RD_NBH: sz <= sz + rd_sz;
      U_TAGS_BP: begin tp <= bp; ts <= sz; ta <= 1'b0; end
      U_TAGS_PB: begin tp <= pb; ts <= sz; ta <= 1'b0; end
      U_BP_PB:   bp <= pb;
      U_MA_INIT: begin
        k    <= (WORD_W'(req) + 32'd15) & TAG_MASK;
        bp   <= WORD_W'(hd);
        walk <= '0;
      end
      U_FF_STEP: begin bp <= rdata; walk <= walk + WALK_W'(1); end
      U_NOFIT:   g <= round_grow((k > chunk_eff) ? k : chunk_eff);
      U_PL_CS:   begin cs <= rd_sz; ra <= bp; end
      U_PL_SPLIT: begin tp <= bp; ts <= k;  ta <= 1'b1; end
      U_PL_WHOLE: begin tp <= bp; ts <= cs; ta <= 1'b1; end
      U_PL_REM: begin
        tp <= bp + k; ts <= cs - k; ta <= 1'b0; ua <= bp + k;
      end
      U_PL_RES: res <= bp[ADDR_W-1:0];
      U_F_SZ:   sz <= rd_sz;
      U_F_TAGS: begin
        tp <= WORD_W'(addr); ts <= sz; ta <= 1'b0; bp <= WORD_W'(addr);
      end
      default: ;
    endcase
  end

  // Output register: loaded at the end of an item, freed by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.uop == U_OUT) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.uop == U_OUT) begin
      out_res <= res;
      out_st  <= status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_st, out_res};

  // Result only loaded when the output register can take it
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.uop == U_OUT) |-> (!out_valid || m_tready))
    else $error("output register overwritten");

  // Growth keeps the break double-word aligned
  a_brk_align: assert property (@(posedge clk) disable iff (rst)
    (cmd.uop == U_GROW_SET) |=> (brk[2:0] == 3'd0))
    else $error("break misaligned after growth");

endmodule

>>> design/efla_ctrl.sv
// Controller state machine of the allocator: sequences datapath micro-ops,
// with a return register for the shared tag, push and unlink routines. Uses efla_pkg.
module efla_ctrl
  import efla_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  ctl_state_t state, state_next;
  ctl_state_t ret, ret_next;

  // State and return registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // Next state and micro-op
  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.uop    = U_NOP;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.uop = U_LATCH; state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.opc)
          OP_INIT:  state_next = S_I0;
          OP_ALLOC: state_next = S_MA0;
          OP_FREE:  state_next = S_F0;
          default:  state_next = S_DONE;
        endcase
      end
      S_ZERO: begin cmd.uop = U_SET_ZERO; state_next = S_DONE; end
      S_OOM:  begin cmd.uop = U_SET_OOM;  state_next = S_DONE; end
      S_DONE: begin
        if (st.out_free) begin
          cmd.uop = U_OUT; state_next = S_IDLE;
        end
      end
      // Heap init
      S_I0: begin
        cmd.uop = U_INIT_CLR; state_next = st.lim_lt16 ? S_OOM : S_I1;
      end
      S_I1: begin cmd.uop = U_INIT_W0; state_next = S_I2; end
      S_I2: begin cmd.uop = U_INIT_W1; state_next = S_I3; end
      S_I3: begin cmd.uop = U_INIT_W2; state_next = S_I4; end
      S_I4: begin cmd.uop = U_INIT_W3; state_next = S_G0; end
      // Grow the break
      S_G0: begin
        if (st.grow_fail) begin
          state_next = S_OOM;
        end else begin
          cmd.uop = U_GROW_SET; state_next = S_T0; ret_next = S_G1;
        end
      end
      S_G1: begin cmd.uop = U_GROW_EPI; state_next = S_MG0; end
      // Write header and footer
      S_T0: begin cmd.uop = U_TAG_HDR; state_next = S_T1; end
      S_T1: begin cmd.uop = U_TAG_FTR; state_next = ret; end
      // Push onto list head
      S_P0: begin cmd.uop = U_PUSH_A; state_next = S_P1; end
      S_P1: begin cmd.uop = U_PUSH_B; state_next = S_P2; end
      S_P2: begin cmd.uop = U_PUSH_C; state_next = ret; end
      // Unlink from list
      S_R0: begin cmd.uop = U_RM_A; state_next = S_R1; end
      S_R1: begin cmd.uop = U_RM_B; state_next = S_R2; end
      S_R2: begin cmd.uop = U_RM_C; state_next = S_R3; end
      S_R3: begin cmd.uop = U_RM_D; state_next = ret; end
      // Coalesce
      S_MG0: begin cmd.uop = U_MG_A; state_next = S_MG1; end
      S_MG1: begin cmd.uop = U_MG_B; state_next = S_MG2; end
      S_MG2: begin
        cmd.uop = U_MG_C;
        if (st.pw0 && st.rd0) begin
          state_next = S_P0; ret_next = S_MG_END;
        end else if (st.pw0) begin
          state_next = S_R0; ret_next = S_MGA0;
        end else if (st.rd0) begin
          state_next = S_MGB0;
        end else begin
          state_next = S_R0; ret_next = S_MGC0;
        end
      end
      S_MGA0: begin cmd.uop = U_RD_NBH; state_next = S_MGA1; end
      S_MGA1: begin cmd.uop = U_SZ_ADD; state_next = S_MGA2; end
      S_MGA2: begin
        cmd.uop = U_TAGS_BP; state_next = S_T0; ret_next = S_MGA3;
      end
      S_MGA3: begin state_next = S_P0; ret_next = S_MG_END; end
      S_MGB0: begin cmd.uop = U_RD_PBH; state_next = S_MGB1; end
      S_MGB1: begin cmd.uop = U_SZ_ADD; state_next = S_MGB2; end
      S_MGB2: begin
        cmd.uop = U_TAGS_PB; state_next = S_T0; ret_next = S_MG_BP;
      end
      S_MG_BP: begin cmd.uop = U_BP_PB; state_next = S_MG_END; end
      S_MGC0: begin cmd.uop = U_RD_PBH; state_next = S_MGC1; end
      S_MGC1: begin cmd.uop = U_SZ_ADD_RD_NBH; state_next = S_MGC2; end
      S_MGC2: begin cmd.uop = U_SZ_ADD; state_next = S_MGC3; end
      S_MGC3: begin
        cmd.uop = U_TAGS_PB; state_next = S_T0; ret_next = S_MG_BP;
      end
      S_MG_END: begin
        state_next = (st.opc == OP_ALLOC) ? S_PL0 : S_DONE;
      end
      // Allocate: first-fit walk
      S_MA0: begin
        if (st.req_zero) begin
          state_next = S_ZERO;
        end else if (st.brk_lt16) begin
          state_next = S_OOM;
        end else begin
          cmd.uop = U_MA_INIT; state_next = S_FF0;
        end
      end
      S_FF0: begin
        if (st.walk_max || st.bp_zero) begin
          state_next = S_NOFIT;
        end else begin
          cmd.uop = U_FF_RD; state_next = S_FF1;
        end
      end
      S_FF1: begin
        if (st.fit) begin
          state_next = S_PL0;
        end else begin
          cmd.uop = U_FF_NEXT_RD; state_next = S_FF2;
        end
      end
      S_FF2:   begin cmd.uop = U_FF_STEP; state_next = S_FF0; end
      S_NOFIT: begin cmd.uop = U_NOFIT;   state_next = S_G0; end
      // Place
      S_PL0: begin cmd.uop = U_PL_RD; state_next = S_PL1; end
      S_PL1: begin
        cmd.uop = U_PL_CS; state_next = S_R0; ret_next = S_PL2;
      end
      S_PL2: begin
        state_next = S_T0;
        if (st.split) begin
          cmd.uop = U_PL_SPLIT; ret_next = S_PL3;
        end else begin
          cmd.uop = U_PL_WHOLE; ret_next = S_PL_END;
        end
      end
      S_PL3: begin
        cmd.uop = U_PL_REM; state_next = S_T0; ret_next = S_PL4;
      end
      S_PL4:    begin state_next = S_P0; ret_next = S_PL_END; end
      S_PL_END: begin cmd.uop = U_PL_RES; state_next = S_DONE; end
      // Free
      S_F0: begin
        if (st.free_pre_ok) begin
          cmd.uop = U_F_RD; state_next = S_F1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F1: begin
        if (st.rd0) begin
          cmd.uop = U_F_SZ; state_next = S_F2;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F2: begin
        if (st.free_sz_ok) begin
          cmd.uop = U_F_TAGS; state_next = S_T0; ret_next = S_MG0;
        end else begin
          state_next = S_DONE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DISPATCH))
    else $error("accepted transfer not dispatched");

  a_walk_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_FF1) |-> (st.opc == OP_ALLOC))
    else $error("list walk outside allocate");

  a_tag_return: assert property (@(posedge clk) disable iff (rst)
    (state == S_T1) |=> (state == $past(ret)))
    else $error("tag routine returned to wrong state");

endmodule

>>> tb/tb_explicit_free_list_allocator.sv
// Self-checking testbench for explicit_free_list_allocator: a directed table, then random
// alloc/free/init/no-op traffic over several register settings, checked against a local heap model.
// Depends on efla_pkg and the allocator RTL only.
module tb_explicit_free_list_allocator;
  import efla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_CHUNK = 0;
  localparam int CFG_LIMIT = 1;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // opcode[1:0], request_size[21:2], block_address[41:22]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // result_address[19:0], status[21:20]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  explicit_free_list_allocator u_top (.*);

  typedef struct {
    logic [19:0] addr;
    status_t     st;
  } alloc_result_t;

  typedef struct {
    opcode_t     op;
    logic [19:0] req;
    logic [19:0] addr;
    bit          fixed;
    logic [19:0] exp_addr;
    status_t     exp_st;
  } step_row_t;

  // Heap model state
  logic [31:0] heap_mem [int unsigned];
  logic [31:0] list_head;
  logic [31:0] brk;
  logic [31:0] chunk_reg;
  logic [31:0] limit_reg;

  alloc_result_t pending_q [$];
  logic [19:0]   live_q [$];
  logic [19:0]   last_freed;
  bit            last_freed_ok;
  bit            quiet;
  int            errors;

  // ---------------- heap model ----------------
  function automatic logic [31:0] hrd(logic [31:0] off);
    int unsigned idx;
    idx = off >> 2;
    if (idx < HEAP_WORDS && heap_mem.exists(idx)) return heap_mem[idx];
    return 32'd0;
  endfunction

  function automatic void hwr(logic [31:0] off, logic [31:0] v);
    int unsigned idx;
    idx = off >> 2;
    if (idx < HEAP_WORDS) heap_mem[idx] = v;
  endfunction

  function automatic logic [31:0] blk_size(logic [31:0] bp);
    return hrd(bp - 32'd4) & ~32'd7;
  endfunction

  function automatic void write_tags(logic [31:0] bp, logic [31:0] sz, logic [31:0] a);
    hwr(bp - 32'd4, sz | a);
    hwr(bp + sz - 32'd8, sz | a);
  endfunction

  function automatic void push_free(logic [31:0] bp);
    if (list_head != 0) hwr(list_head + 32'd4, bp);
    hwr(bp, list_head);
    hwr(bp + 32'd4, 32'd0);
    list_head = bp & 32'hFFFFF;
  endfunction

  function automatic void unlink_free(logic [31:0] bp);
    logic [31:0] prv, nxt;
    prv = hrd(bp + 32'd4);
    nxt = hrd(bp);
    if (prv != 0) hwr(prv, nxt);
    else list_head = nxt & 32'hFFFFF;
    if (nxt != 0) hwr(nxt + 32'd4, prv);
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] bp);
    logic [31:0] sz, nb, pb;
    bit pa, na;
    sz = blk_size(bp);
    nb = bp + sz;
    pa = ((hrd(bp - 32'd8) & 32'd1) != 32'd0);
    na = ((hrd(nb - 32'd4) & 32'd1) != 32'd0);
    if (pa && na) begin
      push_free(bp);
    end else if (pa) begin
      unlink_free(nb);
      sz += blk_size(nb);
      write_tags(bp, sz, 0);
      push_free(bp);
    end else if (na) begin
      pb = bp - (hrd(bp - 32'd8) & ~32'd7);
      sz += blk_size(pb);
      write_tags(pb, sz, 0);
      bp = pb;
    end else begin
      pb = bp - (hrd(bp - 32'd8) & ~32'd7);
      unlink_free(nb);
      sz += blk_size(pb) + blk_size(nb);
      write_tags(pb, sz, 0);
      bp = pb;
    end
    return bp;
  endfunction

  function automatic logic [31:0] eff_limit();
    return (limit_reg < HEAP_WORDS * 4) ? limit_reg : HEAP_WORDS * 4;
  endfunction

  function automatic logic [31:0] grow_heap(logic [31:0] bytes);
    logic [31:0] bp;
    if ({32'd0, brk} + {32'd0, bytes} > {32'd0, eff_limit()}) return 32'd0;
    bp = brk;
    brk += bytes;
    write_tags(bp, bytes, 0);
    hwr(bp + bytes - 32'd4, 32'd1);
    return coalesce(bp);
  endfunction

  function automatic logic [31:0] even_words(logic [31:0] bytes);
    logic [31:0] w;
    w = bytes >> 2;
    return ((w + 32'd1) & ~32'd1) << 2;
  endfunction

  function automatic logic [31:0] first_free_fit(logic [31:0] asize);
    logic [31:0] bp;
    bp = list_head;
    for (int k = 0; k < MAX_WALK && bp != 0; k++) begin
      if (blk_size(bp) >= asize) return bp;
      bp = hrd(bp);
    end
    return 32'd0;
  endfunction

  function automatic void carve(logic [31:0] bp, logic [31:0] asize);
    logic [31:0] cs;
    cs = blk_size(bp);
    unlink_free(bp);
    if (cs >= asize + 32'd16) begin
      write_tags(bp, asize, 1);
      write_tags(bp + asize, cs - asize, 0);
      push_free(bp + asize);
    end else begin
      write_tags(bp, cs, 1);
    end
  endfunction

  // Predicts the answer of one request and advances the heap model
  function automatic alloc_result_t heap_request(opcode_t op, logic [31:0] req,
                                                 logic [31:0] addr);
    alloc_result_t r;
    logic [31:0] chunk, asize, bp, ext, sz;
    chunk = (chunk_reg < 16) ? 32'd16 : chunk_reg;
    r.addr = '0;
    r.st = ST_OK;
    case (op)
      OP_INIT: begin
        list_head = 0;
        brk = 0;
        if (eff_limit() < 16) begin
          r.st = ST_OOM;
        end else begin
          hwr(0, 0);
          hwr(4, 9);
          hwr(8, 9);
          hwr(12, 1);
          brk = 16;
          if (grow_heap(even_words(chunk)) == 0) r.st = ST_OOM;
        end
      end
      OP_ALLOC: begin
        if (req == 0) begin
          r.st = ST_ZERO;
        end else if (brk < 16) begin
          r.st = ST_OOM;
        end else begin
          asize = (req + 32'd15) & ~32'd7;
          bp = first_free_fit(asize);
          if (bp == 0) begin
            ext = (asize > chunk) ? asize : chunk;
            bp = grow_heap(even_words(ext));
          end
          if (bp == 0) begin
            r.st = ST_OOM;
          end else begin
            carve(bp, asize);
            r.addr = bp[19:0];
          end
        end
      end
      OP_FREE: begin
        if (brk >= 16 && addr[2:0] == 0 && addr >= 16 && addr < brk &&
            (hrd(addr - 32'd4) & 32'd1) != 32'd0) begin
          sz = blk_size(addr);
          if (sz >= 16 && {32'd0, addr} + {32'd0, sz} <= {32'd0, brk}) begin
            write_tags(addr, sz, 0);
            void'(coalesce(addr));
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- clock, limit ----------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

  // ---------------- bus tasks ----------------
  task automatic apb_write(int idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= 3'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    if (idx == CFG_CHUNK) chunk_reg = val & 32'h1FFFF;
    else limit_reg = val & 32'h1FFFFF;
  endtask

  // One request transfer; returns right after the accepting edge
  task automatic send_req(opcode_t op, logic [19:0] req, logic [19:0] addr,
                          bit fixed = 0, logic [19:0] ea = '0, status_t es = ST_OK);
    int gap;
    alloc_result_t r;
    gap = quiet ? 0 : $urandom_range(11);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {6'd0, addr, req, op};
    do @(posedge clk); while (!s_tready);
    r = heap_request(op, {12'd0, req}, {12'd0, addr});
    if (fixed) begin
      r.addr = ea;
      r.st = es;
    end
    pending_q.push_back(r);
    if (op == OP_INIT) live_q.delete();
    if (op == OP_ALLOC && r.st == ST_OK && r.addr != 0) live_q.push_back(r.addr);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // ---------------- result side ----------------
  initial begin
    int stall;
    m_tready = 0;
    @(negedge rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(11);
      if (stall > 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        e = pending_q.pop_front();
        if (m_tdata[19:0] !== e.addr || m_tdata[21:20] !== e.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                     e.addr, e.st, m_tdata[19:0], m_tdata[21:20]);
        end
      end
    end
  end

  // ---------------- random traffic ----------------
  task automatic random_phase(int n);
    int r, k;
    logic [19:0] a, q;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_req(OP_INIT, 20'($urandom), 20'($urandom));
        last_freed_ok = 0;
      end else if (r < 4) begin
        send_req(OP_NONE, 20'($urandom), 20'($urandom));
      end else if (r < 7) begin
        send_req(OP_ALLOC, '0, 20'($urandom));
        last_freed_ok = 0;
      end else if (r < 12) begin
        // rejected frees: misaligned, below the prologue, or at or past the break
        case ($urandom_range(2))
          0: a = 20'($urandom) | 20'($urandom_range(1, 7));
          1: a = 20'($urandom_range(0, 15));
          default: a = (brk >= 32'hFFFF8) ? 20'hFFFF8 :
                       20'((brk + 8 * $urandom_range(0, 100)) & 32'hFFFF8);
        endcase
        if (a < brk && a[2:0] == 0 && a >= 16) a = a | 20'd4;
        send_req(OP_FREE, 20'($urandom), a);
        last_freed_ok = 0;
      end else if (r < 16 && last_freed_ok) begin
        send_req(OP_FREE, 20'($urandom), last_freed);
        last_freed_ok = 0;
      end else if (live_q.size() > 0 && (r < 55 || live_q.size() > 30)) begin
        k = $urandom_range(live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
        send_req(OP_FREE, 20'($urandom), a);
        last_freed = a;
        last_freed_ok = 1;
      end else begin
        case ($urandom_range(9))
          0: q = 20'($urandom);
          1: q = 20'($urandom_range(1, 20000));
          default: q = 20'($urandom_range(1, 300));
        endcase
        send_req(OP_ALLOC, q, 20'($urandom));
        last_freed_ok = 0;
      end
    end
  endtask

  // ---------------- main sequence ----------------
  initial begin
    step_row_t rows [$];
    rst      = 1;
    s_tvalid = 0;
    s_tdata  = '0;
    psel     = 0;
    penable  = 0;
    pwrite   = 0;
    paddr    = '0;
    pwdata   = '0;
    errors   = 0;
    quiet    = 0;
    last_freed_ok = 0;
    list_head = 0;
    brk       = 0;
    chunk_reg = CHUNK_RST;
    limit_reg = LIMIT_RST;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed table with default registers
    rows = '{
      '{OP_ALLOC, 20'd64,      20'd0,       1, 20'd0,   ST_OOM},  // before init
      '{OP_FREE,  20'd0,       20'd16,      1, 20'd0,   ST_OK},
      '{OP_NONE,  20'hFFFFF,   20'hFFFFF,   1, 20'd0,   ST_OK},
      '{OP_ALLOC, 20'd0,       20'd0,       1, 20'd0,   ST_ZERO},
      '{OP_INIT,  20'd0,       20'd0,       1, 20'd0,   ST_OK},
      '{OP_ALLOC, 20'd1,       20'd0,       1, 20'd16,  ST_OK},
      '{OP_ALLOC, 20'd0,       20'hFFFFF,   1, 20'd0,   ST_ZERO},
      '{OP_FREE,  20'd0,       20'd3,       1, 20'd0,   ST_OK},
      '{OP_FREE,  20'd0,       20'd0,       1, 20'd0,   ST_OK},
      '{OP_FREE,  20'd0,       20'd8,       1, 20'd0,   ST_OK},
      '{OP_FREE,  20'd0,       20'hFFFF8,   1, 20'd0,   ST_OK},
      '{OP_FREE,  20'd0,       20'hFFFFF,   1, 20'd0,   ST_OK},
      '{OP_ALLOC, 20'hFFFFF,   20'd0,       1, 20'd0,   ST_OOM},
      '{OP_ALLOC, 20'd100,     20'd0,       1, 20'd32,  ST_OK},
      '{OP_ALLOC, 20'd24,      20'd0,       1, 20'd144, ST_OK},
      '{OP_FREE,  20'd0,       20'd16,      1, 20'd0,   ST_OK},
      '{OP_FREE,  20'd0,       20'd16,      1, 20'd0,   ST_OK},   // double free
      '{OP_FREE,  20'd0,       20'd144,     1, 20'd0,   ST_OK},   // next is free
      '{OP_FREE,  20'd0,       20'd32,      1, 20'd0,   ST_OK},   // both sides free
      '{OP_ALLOC, 20'd4000,    20'd0,       0, 20'd0,   ST_OK},
      '{OP_ALLOC, 20'd9000,    20'd0,       0, 20'd0,   ST_OK},   // grows the heap
      '{OP_ALLOC, 20'd8,       20'd0,       0, 20'd0,   ST_OK}
    };
    foreach (rows[i])
      send_req(rows[i].op, rows[i].req, rows[i].addr, rows[i].fixed,
               rows[i].exp_addr, rows[i].exp_st);
    random_phase(230);
    drain();

    // Register settings: tiny heap, no heap, largest values, small chunks
    apb_write(CFG_CHUNK, 16);
    apb_write(CFG_LIMIT, 16);
    send_req(OP_INIT, '0, '0, 1, 20'd0, ST_OOM);   // prologue fits, chunk does not
    random_phase(10);
    drain();

    apb_write(CFG_CHUNK, 0);
    apb_write(CFG_LIMIT, 8);
    send_req(OP_INIT, '0, '0, 1, 20'd0, ST_OOM);   // nothing fits
    random_phase(10);
    drain();

    quiet = 1;
    apb_write(CFG_CHUNK, 65536);
    apb_write(CFG_LIMIT, 32'h1FFFFF);
    send_req(OP_INIT, '0, '0);
    random_phase(180);
    drain();
    quiet = 0;

    apb_write(CFG_CHUNK, 32'h1FFFF);
    apb_write(CFG_LIMIT, 1048576);
    send_req(OP_INIT, '0, '0);
    random_phase(150);
    drain();

    apb_write(CFG_CHUNK, 0);
    apb_write(CFG_LIMIT, 2048);
    send_req(OP_INIT, '0, '0);
    random_phase(180);
    drain();

    apb_write(CFG_CHUNK, 256);
    apb_write(CFG_LIMIT, 65536);
    send_req(OP_INIT, '0, '0);
    random_phase(180);
    drain();

    apb_write(CFG_CHUNK, 4096);
    apb_write(CFG_LIMIT, 1048576);
    send_req(OP_INIT, '0, '0);
    random_phase(180);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
design/efla_pkg.sv
design/efla_datapath.sv
design/efla_ctrl.sv
design/explicit_free_list_allocator.sv
tb/tb_explicit_free_list_allocator.sv
